>>> rtl/core/prm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prm_pkg
// Shared widths, register indexes and types of the pulse run merger.
// ----------------------------------------------------------------------------
package prm_pkg;

   // field widths fixed by the stream format
   localparam int FIELD_TICK_BITS = 15;
   localparam int RUN_BITS        = 24;
   localparam int DIV_BITS        = 8;
   localparam int IDLE_BITS       = 16;
   localparam int US_BITS         = 19;
   localparam int MAG_BITS        = US_BITS - 1;
   localparam int CSR_INDEX_BITS  = 2;
   localparam int CSR_DATA_BITS   = 16;

   // default for the number of ticks bits taken from each half
   localparam int DEF_TICK_BITS   = 15;

   // idle threshold in ticks*divider units: 80*(idle+1) fits 23 bits
   localparam int THR_BITS        = 23;
   localparam int THR_STEPS       = THR_BITS;
   localparam int STEP_BITS       = $clog2(THR_STEPS + 1);

   // conversion: us = ((ticks*div) >> 4) / 5, /5 by reciprocal
   localparam int PROD_BITS       = RUN_BITS + DIV_BITS;
   localparam int QUOT_BITS       = PROD_BITS - 4;
   localparam int RECIP_SHIFT     = 30;
   localparam int RECIP_BITS      = 28;
   localparam logic [RECIP_BITS-1:0] RECIP_5 = 28'd214748365;
   localparam int SCALED_BITS     = QUOT_BITS + RECIP_BITS;
   localparam int CONV_BITS       = SCALED_BITS - RECIP_SHIFT;

   // result queue
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_BITS       = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS       = $clog2(QUEUE_DEPTH + 1);
   localparam int NUM_CANDIDATES  = 5;

   // register reset values
   localparam logic [DIV_BITS-1:0]  CLOCK_DIVIDER_RESET = 8'd80;
   localparam logic [IDLE_BITS-1:0] IDLE_TIME_RESET     = 16'd10000;

   // configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CLOCK_DIVIDER = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDLE_TIME_US  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INVERT_INPUT  = 2'd2;

   // open run
   typedef struct packed {
      logic                level;
      logic [RUN_BITS-1:0] ticks;
      logic                stopped;
   } run_state_type;

   // one finished run waiting to be converted
   typedef struct packed {
      logic                valid;
      logic [RUN_BITS-1:0] ticks;
      logic                level;
      logic                last;
   } run_entry_type;

   // outcome of one half
   typedef struct packed {
      run_state_type st;
      run_entry_type change;
      run_entry_type idle;
   } half_result_type;

endpackage

>>> rtl/core/pulse_run_merger_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_run_merger_top
// Merges two-half capture words into signed microsecond runs.
// ----------------------------------------------------------------------------
// On a capture word the run merge, idle check and frame flush for both halves
// are done at the input edge and the finished runs (0 to 3 per word) go into
// a four-entry queue. The queue drains one run per cycle while the output is
// not stalled, through a three-stage conversion (ticks*divider, reciprocal
// divide by 80, saturate and sign), so words that give at most one run flow at
// one per cycle, and a word that gives more holds the input until the queue is
// back to at most one entry; input is taken while the queue holds at most one
// entry and no threshold is being computed. After reset and after every csr
// write the idle threshold in ticks is recomputed by a bit-serial divider and
// input is held until it is done.
// ----------------------------------------------------------------------------
module pulse_run_merger_top #(
   parameter int TICK_BITS = prm_pkg::DEF_TICK_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   // fields from bit 0: first_level, first_ticks, second_level, second_ticks
   input  logic [31:0]                         req_tdata,
   input  logic                                req_tlast,   // frame_end
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // fields from bit 0: duration_us, zero pad
   output logic [23:0]                         rsp_tdata,
   output logic                                rsp_tlast,   // last_of_frame
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [prm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [prm_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import prm_pkg::*;

   // ------------------------------------------------------------------
   // configuration registers
   logic [DIV_BITS-1:0]  clock_divider_ff;
   logic [IDLE_BITS-1:0] idle_time_ff;
   logic                 invert_ff;
   logic                 csr_write;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         clock_divider_ff <= CLOCK_DIVIDER_RESET;
         idle_time_ff     <= IDLE_TIME_RESET;
         invert_ff        <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_CLOCK_DIVIDER: clock_divider_ff <= csr_data[DIV_BITS-1:0];
            CSR_IDLE_TIME_US:  idle_time_ff     <= csr_data;
            CSR_INVERT_INPUT:  invert_ff        <= csr_data[0];
            default:           ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // idle threshold in ticks: ceil(80*(idle+1) / divider), restoring divide
   logic                 start_ff;
   logic                 busy_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic [THR_BITS-1:0]  num_ff;
   logic [DIV_BITS-1:0]  rem_ff;
   logic [THR_BITS-1:0]  num_load;
   logic [DIV_BITS:0]    rem_shift;
   logic [DIV_BITS:0]    rem_diff;
   logic                 never_idle;

   always_comb begin
      num_load  = {1'b0, idle_time_ff, 6'b0} + {3'b0, idle_time_ff, 4'b0}
                + THR_BITS'(80) + {{(THR_BITS-DIV_BITS){1'b0}}, clock_divider_ff}
                - THR_BITS'(1);
      rem_shift = {rem_ff, num_ff[THR_BITS-1]};
      rem_diff  = rem_shift - {1'b0, clock_divider_ff};
      never_idle = (clock_divider_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         busy_ff  <= 1'b0;
         step_ff  <= '0;
      end else if (csr_write) begin
         start_ff <= 1'b1;
         busy_ff  <= 1'b0;
      end else if (start_ff) begin
         start_ff <= 1'b0;
         busy_ff  <= 1'b1;
         step_ff  <= STEP_BITS'(THR_STEPS);
      end else if (busy_ff) begin
         step_ff <= step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // quotient bits shift into the numerator register
   always_ff @(posedge clock) begin
      if (start_ff) begin
         num_ff <= num_load;
         rem_ff <= '0;
      end else if (busy_ff) begin
         if (!rem_diff[DIV_BITS]) begin
            rem_ff <= rem_diff[DIV_BITS-1:0];
            num_ff <= {num_ff[THR_BITS-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[DIV_BITS-1:0];
            num_ff <= {num_ff[THR_BITS-2:0], 1'b0};
         end
      end
   end

   // ------------------------------------------------------------------
   // run merge for one half
   function automatic half_result_type take_half(
      input run_state_type        st,
      input logic                 lvl,
      input logic [RUN_BITS-1:0]  t,
      input logic [THR_BITS-1:0]  thr,
      input logic                 no_idle
   );
      half_result_type    r;
      logic [RUN_BITS:0]  sum;
      r        = '0;
      r.st     = st;
      sum      = {1'b0, st.ticks} + {1'b0, t};
      if (!st.stopped) begin
         if (t != '0) begin
            if (lvl == st.level) begin
               r.st.ticks = sum[RUN_BITS] ? '1 : sum[RUN_BITS-1:0];
            end else begin
               if (st.ticks != '0) begin
                  r.change = '{valid: 1'b1, ticks: st.ticks, level: st.level, last: 1'b0};
               end
               r.st.level = lvl;
               r.st.ticks = t;
            end
         end
         // run past the idle time ends the frame
         if (!no_idle && (r.st.ticks >= {{(RUN_BITS-THR_BITS){1'b0}}, thr})) begin
            if (r.st.ticks != '0) begin
               r.idle = '{valid: 1'b1, ticks: r.st.ticks, level: r.st.level, last: 1'b1};
            end
            r.st.ticks   = '0;
            r.st.level   = 1'b0;
            r.st.stopped = 1'b1;
         end
      end
      return r;
   endfunction

   // ------------------------------------------------------------------
   // front: merge both halves and the frame end at the input edge
   run_state_type        run_ff;
   run_state_type        run_in;
   logic [RUN_BITS-1:0]  ticks_a;
   logic [RUN_BITS-1:0]  ticks_b;
   half_result_type      half_a;
   half_result_type      half_b;
   run_entry_type        cand [NUM_CANDIDATES];
   logic                 req_accept;
   logic [QCNT_BITS-1:0] count_ff;

   assign req_tready = !start_ff && !busy_ff && (count_ff <= QCNT_BITS'(1));
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      ticks_a = '0;
      ticks_b = '0;
      for (int i = 0; i < FIELD_TICK_BITS; i++) begin
         if (i < TICK_BITS) begin
            ticks_a[i] = req_tdata[1 + i];
            ticks_b[i] = req_tdata[17 + i];
         end
      end
      half_a = take_half(run_ff, req_tdata[0], ticks_a, num_ff, never_idle);
      half_b = take_half(half_a.st, req_tdata[16], ticks_b, num_ff, never_idle);
      cand[0] = half_a.change;
      cand[1] = half_a.idle;
      cand[2] = half_b.change;
      cand[3] = half_b.idle;
      cand[4] = '0;
      run_in  = half_b.st;
      if (req_tlast) begin
         if (!half_b.st.stopped && (half_b.st.ticks != '0)) begin
            cand[4] = '{valid: 1'b1, ticks: half_b.st.ticks,
                        level: half_b.st.level, last: 1'b1};
         end
         run_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= '0;
      end else if (req_accept) begin
         run_ff <= run_in;
      end
   end

   // ------------------------------------------------------------------
   // result queue: up to three pushes, one pop per cycle unless the conversion stalls
   logic [RUN_BITS-1:0]  q_ticks_ff [QUEUE_DEPTH];
   logic                 q_neg_ff   [QUEUE_DEPTH];
   logic                 q_last_ff  [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QPTR_BITS-1:0] wr_idx [NUM_CANDIDATES];
   logic [QCNT_BITS-1:0] push_cnt;
   logic                 pop;

   always_comb begin
      push_cnt = '0;
      for (int k = 0; k < NUM_CANDIDATES; k++) begin
         wr_idx[k] = wr_ptr_ff + push_cnt[QPTR_BITS-1:0];
         push_cnt  = push_cnt + QCNT_BITS'(cand[k].valid);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_accept) begin
            wr_ptr_ff <= wr_ptr_ff + push_cnt[QPTR_BITS-1:0];
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_ff + (req_accept ? push_cnt : '0) - QCNT_BITS'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         for (int k = 0; k < NUM_CANDIDATES; k++) begin
            if (cand[k].valid) begin
               q_ticks_ff[wr_idx[k]] <= cand[k].ticks;
               q_neg_ff[wr_idx[k]]   <= ~cand[k].level ^ invert_ff;
               q_last_ff[wr_idx[k]]  <= cand[k].last;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // conversion pipeline with stall
   logic                  v1_ff, v2_ff, v3_ff;
   logic                  en1, en2, en3;
   logic [PROD_BITS-1:0]  prod_ff;
   logic [CONV_BITS-1:0]  conv_ff;
   logic [SCALED_BITS-1:0] scaled;
   logic                  neg1_ff, neg2_ff, last1_ff, last2_ff;
   logic [MAG_BITS-1:0]   mag;
   logic [US_BITS-1:0]    dur_ff;
   logic                  last3_ff;

   assign en3 = !v3_ff || rsp_tready;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign pop = (count_ff != '0) && en1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= pop;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_comb begin
      scaled = {{RECIP_BITS{1'b0}}, prod_ff[PROD_BITS-1:4]}
             * {{QUOT_BITS{1'b0}}, RECIP_5};
      mag    = (conv_ff[CONV_BITS-1:MAG_BITS] != '0) ? '1 : conv_ff[MAG_BITS-1:0];
   end

   // stage 1: ticks times divider
   always_ff @(posedge clock) begin
      if (en1) begin
         prod_ff  <= {{DIV_BITS{1'b0}}, q_ticks_ff[rd_ptr_ff]}
                   * {{RUN_BITS{1'b0}}, clock_divider_ff};
         neg1_ff  <= q_neg_ff[rd_ptr_ff];
         last1_ff <= q_last_ff[rd_ptr_ff];
      end
   end

   // stage 2: divide by 80
   always_ff @(posedge clock) begin
      if (en2) begin
         conv_ff  <= scaled[SCALED_BITS-1:RECIP_SHIFT];
         neg2_ff  <= neg1_ff;
         last2_ff <= last1_ff;
      end
   end

   // stage 3: saturate and apply sign
   always_ff @(posedge clock) begin
      if (en3) begin
         dur_ff   <= neg2_ff ? (US_BITS'(0) - {1'b0, mag}) : {1'b0, mag};
         last3_ff <= last2_ff;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {{(24-US_BITS){1'b0}}, dur_ff};
   assign rsp_tlast  = last3_ff;

endmodule
